// File: rtl/lswc_pkg.sv
`default_nettype none
package lswc_pkg;

	// coordinate and arithmetic widths
	localparam int COORD_BITS = 16;
	localparam int WW         = 12;
	localparam int SW         = COORD_BITS + 2;
	localparam int DW         = COORD_BITS + 1;
	localparam int PW         = 2 * DW;
	localparam int QW         = (PW > 41) ? 41 : PW;
	localparam int AW         = QW + 2;
	localparam int EW         = (PW > 42) ? PW : 42;
	localparam int MOVE_SHIFT = 40;
	localparam int DIV_CW     = $clog2(PW + 1);

	// queue depths, powers of two
	localparam int JQ_DEPTH = 2;
	localparam int JQ_PW    = (JQ_DEPTH > 1) ? $clog2(JQ_DEPTH) : 1;
	localparam int JQ_CW    = $clog2(JQ_DEPTH + 1);
	localparam int OQ_DEPTH = 2;
	localparam int OQ_PW    = (OQ_DEPTH > 1) ? $clog2(OQ_DEPTH) : 1;
	localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

	// configuration register indexes
	localparam int CFG_IW = 2;
	localparam logic [CFG_IW-1:0] CFG_WIN_LEFT   = 2'd0;
	localparam logic [CFG_IW-1:0] CFG_WIN_RIGHT  = 2'd1;
	localparam logic [CFG_IW-1:0] CFG_WIN_TOP    = 2'd2;
	localparam logic [CFG_IW-1:0] CFG_WIN_BOTTOM = 2'd3;

	typedef struct packed {
		logic [WW-1:0] left;
		logic [WW-1:0] right;
		logic [WW-1:0] top;
		logic [WW-1:0] bottom;
	} win_t;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] x1;
		logic signed [COORD_BITS-1:0] y1;
		logic signed [COORD_BITS-1:0] x2;
		logic signed [COORD_BITS-1:0] y2;
		logic [DW-1:0]                adx;
		logic [DW-1:0]                ady;
		logic                         pos;
		logic                         trivial;
	} job_t;

	typedef struct packed {
		logic [WW-1:0] from_x;
		logic [WW-1:0] from_y;
		logic [WW-1:0] to_x;
		logic [WW-1:0] to_y;
		logic          last;
	} res_t;

	typedef struct packed {
		logic [QW-1:0] q;
		logic          rnz;
	} mv_t;

	// integer part of a move saturates at 2^40
	function automatic logic [QW-1:0] sat_move(input logic [PW-1:0] q);
		logic [EW-1:0] e;
		logic [EW-1:0] lim;
		e   = EW'(q);
		lim = EW'(1) << MOVE_SHIFT;
		return (e > lim) ? QW'(lim) : QW'(e);
	endfunction

	// larger of a fractional move and an integer distance
	function automatic mv_t larger(input mv_t f, input logic [DW-1:0] t);
		mv_t r;
		r = f;
		if (!(f.q > QW'(t) || (f.q == QW'(t) && f.rnz))) begin
			r.q   = QW'(t);
			r.rnz = 1'b0;
		end
		return r;
	endfunction

	// base plus or minus move, truncated toward zero
	function automatic logic signed [AW-1:0] apply(input logic signed [AW-1:0] base,
		input logic neg, input mv_t f);
		logic signed [AW-1:0] m;
		logic signed [AW-1:0] s;
		m = $signed(AW'({1'b0, f.q}));
		s = neg ? (base - m) : (base + m);
		if (!neg && s < 0 && f.rnz) begin
			s = s + AW'(1);
		end
		if (neg && s > 0 && f.rnz) begin
			s = s - AW'(1);
		end
		return s;
	endfunction

	// low edge first, then high edge wins
	function automatic logic [WW-1:0] clamp(input logic signed [AW-1:0] v,
		input logic [WW-1:0] lo, input logic [WW-1:0] hi);
		logic signed [AW-1:0] r;
		r = v;
		if (r < $signed(AW'({1'b0, lo}))) begin
			r = $signed(AW'({1'b0, lo}));
		end
		if (r > $signed(AW'({1'b0, hi}))) begin
			r = $signed(AW'({1'b0, hi}));
		end
		return r[WW-1:0];
	endfunction

endpackage
`default_nettype wire

// File: rtl/lswc_front.sv
`default_nettype none
module lswc_front (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   push,
	output logic                                        full,
	input  wire logic signed [lswc_pkg::COORD_BITS-1:0] start_x,
	input  wire logic signed [lswc_pkg::COORD_BITS-1:0] start_y,
	input  wire logic signed [lswc_pkg::COORD_BITS-1:0] end_x,
	input  wire logic signed [lswc_pkg::COORD_BITS-1:0] end_y,
	input  wire lswc_pkg::win_t                         win,
	input  wire logic                                   jq_full,
	output logic                                        jq_push,
	output lswc_pkg::job_t                              jq_data
);

	logic                                   valid_s1;
	logic signed [lswc_pkg::COORD_BITS-1:0] x1_s1, y1_s1, x2_s1, y2_s1;
	logic signed [lswc_pkg::SW-1:0]         ex1, ey1, ex2, ey2, wl, wr, wt, wb, dx, dy;
	logic                                   out1, out2, beyond;

	assign full    = valid_s1 && jq_full;
	assign jq_push = valid_s1 && !jq_full;

	// input register stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!full) begin
			valid_s1 <= push;
		end
	end

	always_ff @(posedge clk) begin
		if (push && !full) begin
			x1_s1 <= start_x;
			y1_s1 <= start_y;
			x2_s1 <= end_x;
			y2_s1 <= end_y;
		end
	end

	// classify against the window
	always_comb begin
		ex1 = lswc_pkg::SW'(x1_s1);
		ey1 = lswc_pkg::SW'(y1_s1);
		ex2 = lswc_pkg::SW'(x2_s1);
		ey2 = lswc_pkg::SW'(y2_s1);
		wl  = $signed(lswc_pkg::SW'({1'b0, win.left}));
		wr  = $signed(lswc_pkg::SW'({1'b0, win.right}));
		wt  = $signed(lswc_pkg::SW'({1'b0, win.top}));
		wb  = $signed(lswc_pkg::SW'({1'b0, win.bottom}));
		out1 = ex1 < wl || ex1 > wr || ey1 < wt || ey1 > wb;
		out2 = ex2 < wl || ex2 > wr || ey2 < wt || ey2 > wb;
		beyond = (ex1 < wl && ex2 < wl) || (ex1 > wr && ex2 > wr) ||
			(ey1 < wt && ey2 < wt) || (ey1 > wb && ey2 > wb);
		dx = ex2 - ex1;
		dy = ey1 - ey2;
		jq_data.x1  = x1_s1;
		jq_data.y1  = y1_s1;
		jq_data.x2  = x2_s1;
		jq_data.y2  = y2_s1;
		jq_data.adx = (dx < 0) ? lswc_pkg::DW'(-dx) : lswc_pkg::DW'(dx);
		jq_data.ady = (dy < 0) ? lswc_pkg::DW'(-dy) : lswc_pkg::DW'(dy);
		jq_data.pos = (dx < 0) == (dy < 0);
		jq_data.trivial = (!out1 && !out2) || (x1_s1 == x2_s1) || (y1_s1 == y2_s1) || beyond;
	end

endmodule
`default_nettype wire

// File: rtl/lswc_jobq.sv
`default_nettype none
module lswc_jobq (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire lswc_pkg::job_t wdata,
	output logic                full,
	input  wire logic           pop,
	output lswc_pkg::job_t      rdata,
	output logic                empty
);

	lswc_pkg::job_t                mem_q [lswc_pkg::JQ_DEPTH];
	logic [lswc_pkg::JQ_PW-1:0]    wp_q, rp_q;
	logic [lswc_pkg::JQ_CW-1:0]    cnt_q;

	assign full  = cnt_q == lswc_pkg::JQ_CW'(lswc_pkg::JQ_DEPTH);
	assign empty = cnt_q == '0;
	assign rdata = mem_q[rp_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + lswc_pkg::JQ_PW'(1);
			end
			if (pop) begin
				rp_q <= rp_q + lswc_pkg::JQ_PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + lswc_pkg::JQ_CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - lswc_pkg::JQ_CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wdata;
		end
	end

endmodule
`default_nettype wire

// File: rtl/lswc_div.sv
`default_nettype none
module lswc_div (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [lswc_pkg::PW-1:0]   num,
	input  wire logic [lswc_pkg::DW-1:0]   den,
	output logic                           done,
	output logic [lswc_pkg::PW-1:0]        quo,
	output logic                           rnz
);

	logic                          busy_q, done_q;
	logic [lswc_pkg::DIV_CW-1:0]   cnt_q;
	logic [lswc_pkg::DW-1:0]       rem_q, den_q;
	logic [lswc_pkg::PW-1:0]       quo_q;
	logic [lswc_pkg::DW:0]         trial, diff;
	logic                          ge;

	assign done = done_q;
	assign quo  = quo_q;
	assign rnz  = |rem_q;

	// one restoring step per cycle
	always_comb begin
		trial = {rem_q, quo_q[lswc_pkg::PW-1]};
		ge    = trial >= {1'b0, den_q};
		diff  = trial - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= lswc_pkg::DIV_CW'(lswc_pkg::PW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - lswc_pkg::DIV_CW'(1);
				if (cnt_q == lswc_pkg::DIV_CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			quo_q <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= ge ? diff[lswc_pkg::DW-1:0] : trial[lswc_pkg::DW-1:0];
			quo_q <= {quo_q[lswc_pkg::PW-2:0], ge};
		end
	end

endmodule
`default_nettype wire

// File: rtl/lswc_back.sv
`default_nettype none
module lswc_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire lswc_pkg::win_t win,
	input  wire logic           jq_empty,
	input  wire lswc_pkg::job_t jq_data,
	output logic                jq_pop,
	input  wire logic           oq_full,
	output logic                oq_push,
	output lswc_pkg::res_t      oq_data
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_CLS  = 3'd1;
	localparam logic [2:0] ST_MUL  = 3'd2;
	localparam logic [2:0] ST_DST  = 3'd3;
	localparam logic [2:0] ST_DIV  = 3'd4;
	localparam logic [2:0] ST_PT   = 3'd5;
	localparam logic [2:0] ST_EMIT = 3'd6;
	localparam logic [2:0] ST_MAIN = 3'd7;

	localparam logic [2:0] RGN_IN     = 3'd0;
	localparam logic [2:0] RGN_CORNER = 3'd1;
	localparam logic [2:0] RGN_LEFT   = 3'd2;
	localparam logic [2:0] RGN_RIGHT  = 3'd3;
	localparam logic [2:0] RGN_BOTTOM = 3'd4;
	localparam logic [2:0] RGN_TOP    = 3'd5;

	logic [2:0]                      state_q, rgn_q, rgn_d;
	logic                            ep_q, idx_q, right_q, down_q, right_d, down_d;
	lswc_pkg::job_t                  job_q;
	logic [lswc_pkg::DW-1:0]         hx_q, hy_q, hx_d, hy_d, mul_a, mul_b, div_den;
	logic [lswc_pkg::PW-1:0]         prod_q, div_quo;
	lswc_pkg::mv_t                   m0_q, m1_q, mv, bx, by;
	logic signed [lswc_pkg::AW-1:0]  fx_q, fy_q, tx_q, ty_q, cx_q, cy_q, nx_q, ny_q;
	logic signed [lswc_pkg::AW-1:0]  px, py, wl, wr, wt, wb, nx_d, ny_d, cx_d, cy_d;
	logic                            ysel, div_start, div_done, div_rnz;

	// window and current endpoint
	always_comb begin
		wl = $signed(lswc_pkg::AW'({1'b0, win.left}));
		wr = $signed(lswc_pkg::AW'({1'b0, win.right}));
		wt = $signed(lswc_pkg::AW'({1'b0, win.top}));
		wb = $signed(lswc_pkg::AW'({1'b0, win.bottom}));
		px = ep_q ? lswc_pkg::AW'(job_q.x2) : lswc_pkg::AW'(job_q.x1);
		py = ep_q ? lswc_pkg::AW'(job_q.y2) : lswc_pkg::AW'(job_q.y1);
	end

	// region of the endpoint and its distances to the border
	always_comb begin
		rgn_d   = RGN_IN;
		right_d = px < wl;
		down_d  = py < wt;
		hx_d    = '0;
		hy_d    = '0;
		if ((px < wl || px > wr) && (py > wb || py < wt)) begin
			rgn_d = RGN_CORNER;
			if (px < wl && py > wb) begin
				right_d = 1'b1;
				down_d  = 1'b0;
			end
			hx_d = right_d ? lswc_pkg::DW'(wl - px) : lswc_pkg::DW'(px - wr);
			hy_d = down_d ? lswc_pkg::DW'(wt - py) : lswc_pkg::DW'(py - wb);
		end else if (px < wl) begin
			rgn_d = RGN_LEFT;
			hx_d  = lswc_pkg::DW'(wl - px);
		end else if (px > wr) begin
			rgn_d = RGN_RIGHT;
			hx_d  = lswc_pkg::DW'(px - wr);
		end else if (py > wb) begin
			rgn_d = RGN_BOTTOM;
			hy_d  = lswc_pkg::DW'(py - wb);
		end else if (py < wt) begin
			rgn_d = RGN_TOP;
			hy_d  = lswc_pkg::DW'(wt - py);
		end
	end

	// operand selection: move along y or along x
	always_comb begin
		ysel    = idx_q || rgn_q == RGN_BOTTOM || rgn_q == RGN_TOP;
		mul_a   = ysel ? job_q.adx : job_q.ady;
		mul_b   = ysel ? hy_q : hx_q;
		div_den = ysel ? job_q.ady : job_q.adx;
		div_start = state_q == ST_DST;
		mv.q    = lswc_pkg::sat_move(div_quo);
		mv.rnz  = div_rnz;
	end

	lswc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (prod_q),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo),
		.rnz    (div_rnz)
	);

	// entry point on the border
	always_comb begin
		by   = lswc_pkg::larger(m0_q, hy_q);
		bx   = lswc_pkg::larger(m1_q, hx_q);
		nx_d = px;
		ny_d = py;
		cx_d = px;
		cy_d = py;
		case (rgn_q)
			RGN_CORNER: begin
				nx_d = lswc_pkg::apply(px, !right_q, bx);
				ny_d = lswc_pkg::apply(py, !down_q, by);
				cx_d = right_q ? wl : wr;
				cy_d = down_q ? wt : wb;
			end
			RGN_LEFT: begin
				nx_d = wl;
				ny_d = lswc_pkg::apply(py, job_q.pos, m0_q);
				cx_d = wl;
			end
			RGN_RIGHT: begin
				nx_d = wr;
				ny_d = lswc_pkg::apply(py, !job_q.pos, m0_q);
				cx_d = wr;
			end
			RGN_BOTTOM: begin
				nx_d = lswc_pkg::apply(px, !job_q.pos, m0_q);
				ny_d = wb;
				cy_d = wb;
			end
			RGN_TOP: begin
				nx_d = lswc_pkg::apply(px, job_q.pos, m0_q);
				ny_d = wt;
				cy_d = wt;
			end
			default: begin
			end
		endcase
	end

	// job queue pop and result requests toward the output queue
	always_comb begin
		jq_pop  = state_q == ST_IDLE && !jq_empty;
		oq_push = (state_q == ST_EMIT || state_q == ST_MAIN) && !oq_full;
		if (state_q == ST_EMIT) begin
			oq_data.from_x = lswc_pkg::clamp(cx_q, win.left, win.right);
			oq_data.from_y = lswc_pkg::clamp(cy_q, win.top, win.bottom);
			oq_data.to_x   = lswc_pkg::clamp(nx_q, win.left, win.right);
			oq_data.to_y   = lswc_pkg::clamp(ny_q, win.top, win.bottom);
			oq_data.last   = 1'b0;
		end else begin
			oq_data.from_x = lswc_pkg::clamp(fx_q, win.left, win.right);
			oq_data.from_y = lswc_pkg::clamp(fy_q, win.top, win.bottom);
			oq_data.to_x   = lswc_pkg::clamp(tx_q, win.left, win.right);
			oq_data.to_y   = lswc_pkg::clamp(ty_q, win.top, win.bottom);
			oq_data.last   = 1'b1;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ep_q    <= 1'b0;
			idx_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (!jq_empty) begin
						ep_q    <= 1'b0;
						state_q <= jq_data.trivial ? ST_MAIN : ST_CLS;
					end
				end
				ST_CLS: begin
					idx_q <= 1'b0;
					if (rgn_d != RGN_IN) begin
						state_q <= ST_MUL;
					end else if (!ep_q) begin
						ep_q <= 1'b1;
					end else begin
						state_q <= ST_MAIN;
					end
				end
				ST_MUL: begin
					state_q <= ST_DST;
				end
				ST_DST: begin
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (div_done) begin
						if (rgn_q == RGN_CORNER && !idx_q) begin
							idx_q   <= 1'b1;
							state_q <= ST_MUL;
						end else begin
							state_q <= ST_PT;
						end
					end
				end
				ST_PT: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (!oq_full) begin
						if (!ep_q) begin
							ep_q    <= 1'b1;
							state_q <= ST_CLS;
						end else begin
							state_q <= ST_MAIN;
						end
					end
				end
				ST_MAIN: begin
					if (!oq_full) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && !jq_empty) begin
			job_q <= jq_data;
			fx_q  <= lswc_pkg::AW'(jq_data.x1);
			fy_q  <= lswc_pkg::AW'(jq_data.y1);
			tx_q  <= lswc_pkg::AW'(jq_data.x2);
			ty_q  <= lswc_pkg::AW'(jq_data.y2);
		end
		if (state_q == ST_CLS) begin
			rgn_q   <= rgn_d;
			right_q <= right_d;
			down_q  <= down_d;
			hx_q    <= hx_d;
			hy_q    <= hy_d;
		end
		if (state_q == ST_MUL) begin
			prod_q <= lswc_pkg::PW'(mul_a) * lswc_pkg::PW'(mul_b);
		end
		if (state_q == ST_DIV && div_done) begin
			if (!idx_q) begin
				m0_q <= mv;
			end else begin
				m1_q <= mv;
			end
		end
		if (state_q == ST_PT) begin
			cx_q <= cx_d;
			cy_q <= cy_d;
			nx_q <= nx_d;
			ny_q <= ny_d;
			if (!ep_q) begin
				fx_q <= nx_d;
				fy_q <= ny_d;
			end else begin
				tx_q <= nx_d;
				ty_q <= ny_d;
			end
		end
	end

endmodule
`default_nettype wire

// File: rtl/lswc_outq.sv
`default_nettype none
module lswc_outq (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire lswc_pkg::res_t wdata,
	output logic                full,
	input  wire logic           pop,
	output lswc_pkg::res_t      rdata,
	output logic                empty
);

	lswc_pkg::res_t                mem_q [lswc_pkg::OQ_DEPTH];
	logic [lswc_pkg::OQ_PW-1:0]    wp_q, rp_q;
	logic [lswc_pkg::OQ_CW-1:0]    cnt_q;
	logic                          do_pop;

	assign full   = cnt_q == lswc_pkg::OQ_CW'(lswc_pkg::OQ_DEPTH);
	assign empty  = cnt_q == '0;
	assign rdata  = mem_q[rp_q];
	assign do_pop = pop && !empty;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + lswc_pkg::OQ_PW'(1);
			end
			if (do_pop) begin
				rp_q <= rp_q + lswc_pkg::OQ_PW'(1);
			end
			if (push && !do_pop) begin
				cnt_q <= cnt_q + lswc_pkg::OQ_CW'(1);
			end else if (do_pop && !push) begin
				cnt_q <= cnt_q - lswc_pkg::OQ_CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= wdata;
		end
	end

endmodule
`default_nettype wire

// File: rtl/line_segment_window_clipper.sv
// channel   direction  handshake            payload
// line in   input      push / full          start_x start_y end_x end_y
// segment   output     empty / pop          seg_from_x seg_from_y seg_to_x seg_to_y seg_last
// config    input      cfg_valid/cfg_ready  cfg_index cfg_data
//
// a line that is inside, axis aligned or wholly beyond one edge yields one segment and needs no division
// each outside endpoint takes one division (two in a corner region) in the bit-serial
// divider, then its entry point is registered and its border segment is emitted; the
// divider sets the rate of clipped lines
// the front register and a 2-deep line queue accept new lines while the back works
// async active-low reset clears queues and control; window resets to 0..1023
`default_nettype none
module line_segment_window_clipper (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   push,
	output logic                                        full,
	input  wire logic signed [lswc_pkg::COORD_BITS-1:0] start_x,
	input  wire logic signed [lswc_pkg::COORD_BITS-1:0] start_y,
	input  wire logic signed [lswc_pkg::COORD_BITS-1:0] end_x,
	input  wire logic signed [lswc_pkg::COORD_BITS-1:0] end_y,
	output logic                                        empty,
	input  wire logic                                   pop,
	output logic [lswc_pkg::WW-1:0]                     seg_from_x,
	output logic [lswc_pkg::WW-1:0]                     seg_from_y,
	output logic [lswc_pkg::WW-1:0]                     seg_to_x,
	output logic [lswc_pkg::WW-1:0]                     seg_to_y,
	output logic                                        seg_last,
	input  wire logic                                   cfg_valid,
	output logic                                        cfg_ready,
	input  wire logic [lswc_pkg::CFG_IW-1:0]            cfg_index,
	input  wire logic [lswc_pkg::WW-1:0]                cfg_data
);

	lswc_pkg::win_t win_q;
	lswc_pkg::job_t jq_wdata, jq_rdata;
	lswc_pkg::res_t oq_wdata, oq_rdata;
	logic           jq_push, jq_full, jq_pop, jq_empty, oq_push, oq_full;

	assign cfg_ready = 1'b1;

	// window registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q.left   <= lswc_pkg::WW'(0);
			win_q.right  <= lswc_pkg::WW'(1023);
			win_q.top    <= lswc_pkg::WW'(0);
			win_q.bottom <= lswc_pkg::WW'(1023);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				lswc_pkg::CFG_WIN_LEFT:   win_q.left   <= cfg_data;
				lswc_pkg::CFG_WIN_RIGHT:  win_q.right  <= cfg_data;
				lswc_pkg::CFG_WIN_TOP:    win_q.top    <= cfg_data;
				lswc_pkg::CFG_WIN_BOTTOM: win_q.bottom <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	lswc_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.start_x (start_x),
		.start_y (start_y),
		.end_x   (end_x),
		.end_y   (end_y),
		.win     (win_q),
		.jq_full (jq_full),
		.jq_push (jq_push),
		.jq_data (jq_wdata)
	);

	lswc_jobq u_jobq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (jq_push),
		.wdata  (jq_wdata),
		.full   (jq_full),
		.pop    (jq_pop),
		.rdata  (jq_rdata),
		.empty  (jq_empty)
	);

	lswc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.win      (win_q),
		.jq_empty (jq_empty),
		.jq_data  (jq_rdata),
		.jq_pop   (jq_pop),
		.oq_full  (oq_full),
		.oq_push  (oq_push),
		.oq_data  (oq_wdata)
	);

	lswc_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (oq_push),
		.wdata  (oq_wdata),
		.full   (oq_full),
		.pop    (pop),
		.rdata  (oq_rdata),
		.empty  (empty)
	);

	assign seg_from_x = oq_rdata.from_x;
	assign seg_from_y = oq_rdata.from_y;
	assign seg_to_x   = oq_rdata.to_x;
	assign seg_to_y   = oq_rdata.to_y;
	assign seg_last   = oq_rdata.last;

endmodule
`default_nettype wire

// File: rtl/lswc_checker.sv
`default_nettype none
module lswc_checker (
	input wire logic                                   clk,
	input wire logic                                   arst_n,
	input wire logic                                   push,
	input wire logic                                   full,
	input wire logic                                   empty,
	input wire logic                                   pop,
	input wire logic [lswc_pkg::WW-1:0]                seg_from_x,
	input wire logic [lswc_pkg::WW-1:0]                seg_from_y,
	input wire logic [lswc_pkg::WW-1:0]                seg_to_x,
	input wire logic [lswc_pkg::WW-1:0]                seg_to_y,
	input wire logic                                   seg_last,
	input wire logic                                   cfg_valid,
	input wire logic                                   cfg_ready,
	input wire logic [lswc_pkg::CFG_IW-1:0]            cfg_index,
	input wire logic [lswc_pkg::WW-1:0]                cfg_data
);

	lswc_pkg::win_t win_q;
	logic [3:0]     pend_q;
	logic           line_in, last_out;

	assign line_in  = push && !full;
	assign last_out = pop && !empty && seg_last;

	// shadow of the window registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q.left   <= lswc_pkg::WW'(0);
			win_q.right  <= lswc_pkg::WW'(1023);
			win_q.top    <= lswc_pkg::WW'(0);
			win_q.bottom <= lswc_pkg::WW'(1023);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				lswc_pkg::CFG_WIN_LEFT:   win_q.left   <= cfg_data;
				lswc_pkg::CFG_WIN_RIGHT:  win_q.right  <= cfg_data;
				lswc_pkg::CFG_WIN_TOP:    win_q.top    <= cfg_data;
				lswc_pkg::CFG_WIN_BOTTOM: win_q.bottom <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// lines accepted whose last segment has not left yet
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (line_in && !last_out) begin
			pend_q <= pend_q + 4'd1;
		end else if (last_out && !line_in) begin
			pend_q <= pend_q - 4'd1;
		end
	end

	// a segment only shows up for a line that was taken in
	a_no_orphan: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> pend_q != 4'd0)
		else $error("segment without an outstanding line");

	// every segment lies inside a well-formed window
	a_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && win_q.left <= win_q.right && win_q.top <= win_q.bottom) |->
		(seg_from_x >= win_q.left && seg_from_x <= win_q.right &&
		 seg_to_x >= win_q.left && seg_to_x <= win_q.right &&
		 seg_from_y >= win_q.top && seg_from_y <= win_q.bottom &&
		 seg_to_y >= win_q.top && seg_to_y <= win_q.bottom))
		else $error("segment outside window");

	// a waiting segment is not withdrawn
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> !empty)
		else $error("segment withdrawn before pop");

	// a waiting segment keeps its from_x, to_y and last values
	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> ($stable(seg_from_x) && $stable(seg_to_y) && $stable(seg_last)))
		else $error("segment changed before pop");

endmodule

bind line_segment_window_clipper lswc_checker u_lswc_checker (.*);
`default_nettype wire

// File: test/line_segment_window_clipper_tb.sv
`default_nettype none
module line_segment_window_clipper_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint MOVE_CAP  = 64'd1 << 40;
	localparam int     TIMEOUT   = 2000000;
	localparam int     IDLE_WAIT = 200;

	typedef struct {
		longint q;
		bit     rnz;
	} move_t;

	typedef struct {
		logic [lswc_pkg::WW-1:0] fx;
		logic [lswc_pkg::WW-1:0] fy;
		logic [lswc_pkg::WW-1:0] tx;
		logic [lswc_pkg::WW-1:0] ty;
		logic                    last;
	} seg_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	logic signed [lswc_pkg::COORD_BITS-1:0] start_x = '0;
	logic signed [lswc_pkg::COORD_BITS-1:0] start_y = '0;
	logic signed [lswc_pkg::COORD_BITS-1:0] end_x = '0;
	logic signed [lswc_pkg::COORD_BITS-1:0] end_y = '0;
	logic empty;
	logic pop = 1'b0;
	logic [lswc_pkg::WW-1:0] seg_from_x, seg_from_y, seg_to_x, seg_to_y;
	logic seg_last;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [lswc_pkg::CFG_IW-1:0] cfg_index = '0;
	logic [lswc_pkg::WW-1:0] cfg_data = '0;

	// window copy used for prediction
	longint win_l = 0, win_r = 1023, win_t = 0, win_b = 1023;
	seg_t expected_segs[$];
	int errors = 0;
	longint cycle = 0;
	int burst_left = 0;

	line_segment_window_clipper dut (.*);

	always #4 clk = ~clk;

	// run length limit
	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle > TIMEOUT) begin
			$display("status: fail");
			$finish;
		end
	end

	// result stall pattern: stall runs and free runs
	int stall_mode = 0;
	always @(negedge clk) begin
		if (stall_mode == 0) pop <= 1'b1;
		else if (stall_mode == 1) pop <= ($urandom_range(0, 3) != 0);
		else pop <= ($urandom_range(0, 3) == 0);
		if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
	end

	// check each segment request against the oldest prediction
	always @(posedge clk) begin
		seg_t e;
		if (arst_n && pop && !empty) begin
			if (expected_segs.size() == 0) begin
				$error("segment with no prediction waiting");
				errors++;
			end else begin
				e = expected_segs.pop_front();
				if (seg_from_x !== e.fx) begin
					$error("seg_from_x exp %0d got %0d", e.fx, seg_from_x); errors++;
				end
				if (seg_from_y !== e.fy) begin
					$error("seg_from_y exp %0d got %0d", e.fy, seg_from_y); errors++;
				end
				if (seg_to_x !== e.tx) begin
					$error("seg_to_x exp %0d got %0d", e.tx, seg_to_x); errors++;
				end
				if (seg_to_y !== e.ty) begin
					$error("seg_to_y exp %0d got %0d", e.ty, seg_to_y); errors++;
				end
				if (seg_last !== e.last) begin
					$error("seg_last exp %0d got %0d", e.last, seg_last); errors++;
				end
			end
		end
	end

	function automatic move_t scale_move(longint a, longint b, longint d);
		move_t m;
		longint n;
		n = a * b;
		m.q = n / d;
		m.rnz = (n % d) != 0;
		if (m.q > MOVE_CAP) m.q = MOVE_CAP;
		return m;
	endfunction

	function automatic move_t max_move(move_t f, longint t);
		if (f.q > t || (f.q == t && f.rnz)) return f;
		f.q = t;
		f.rnz = 1'b0;
		return f;
	endfunction

	function automatic longint step_along(longint base, bit neg, move_t f);
		longint s;
		if (!neg) begin
			s = base + f.q;
			if (s < 0 && f.rnz) s += 1;
		end else begin
			s = base - f.q;
			if (s > 0 && f.rnz) s -= 1;
		end
		return s;
	endfunction

	function automatic logic [lswc_pkg::WW-1:0] fit(longint v, longint lo, longint hi);
		if (v < lo) v = lo;
		if (v > hi) v = hi;
		return lswc_pkg::WW'(v);
	endfunction

	function automatic seg_t clipped_seg(longint ax, longint ay, longint bx, longint by,
		bit last);
		seg_t s;
		s.fx = fit(ax, win_l, win_r);
		s.fy = fit(ay, win_t, win_b);
		s.tx = fit(bx, win_l, win_r);
		s.ty = fit(by, win_t, win_b);
		s.last = last;
		return s;
	endfunction

	// border segment for an outside endpoint; returns 0 if inside
	function automatic bit border_entry(longint px, longint py, longint adx, longint ady,
		bit pos, output seg_t s, output longint nx, output longint ny);
		longint cx, cy, hx, hy;
		bit right, down;
		move_t oy, ox;
		if ((px < win_l || px > win_r) && (py > win_b || py < win_t)) begin
			right = px < win_l;
			down = py < win_t;
			if (px < win_l && py > win_b) begin
				right = 1; down = 0;
			end
			cx = right ? win_l : win_r;
			cy = down ? win_t : win_b;
			hx = right ? win_l - px : px - win_r;
			hy = down ? win_t - py : py - win_b;
			oy = max_move(scale_move(ady, hx, adx), hy);
			ox = max_move(scale_move(adx, hy, ady), hx);
			nx = step_along(px, !right, ox);
			ny = step_along(py, !down, oy);
		end else if (px < win_l) begin
			cx = win_l; cy = py; nx = win_l;
			ny = step_along(py, pos, scale_move(ady, win_l - px, adx));
		end else if (px > win_r) begin
			cx = win_r; cy = py; nx = win_r;
			ny = step_along(py, !pos, scale_move(ady, px - win_r, adx));
		end else if (py > win_b) begin
			cx = px; cy = win_b; ny = win_b;
			nx = step_along(px, !pos, scale_move(adx, py - win_b, ady));
		end else if (py < win_t) begin
			cx = px; cy = win_t; ny = win_t;
			nx = step_along(px, pos, scale_move(adx, win_t - py, ady));
		end else begin
			nx = px; ny = py;
			return 0;
		end
		s = clipped_seg(cx, cy, nx, ny, 0);
		return 1;
	endfunction

	function automatic bit off_window(longint x, longint y);
		return x < win_l || x > win_r || y < win_t || y > win_b;
	endfunction

	// predict the segments of one line
	function automatic void predict_clip(longint x1, longint y1, longint x2, longint y2);
		longint dx, dy, adx, ady, fx, fy, tx, ty;
		bit pos, beyond;
		seg_t s;
		beyond = (x1 < win_l && x2 < win_l) || (x1 > win_r && x2 > win_r) ||
			(y1 < win_t && y2 < win_t) || (y1 > win_b && y2 > win_b);
		if ((!off_window(x1, y1) && !off_window(x2, y2)) || x1 == x2 || y1 == y2 ||
			beyond) begin
			expected_segs.push_back(clipped_seg(x1, y1, x2, y2, 1));
			return;
		end
		dx = x2 - x1;
		dy = y1 - y2;
		adx = dx < 0 ? -dx : dx;
		ady = dy < 0 ? -dy : dy;
		pos = (dx < 0) == (dy < 0);
		if (border_entry(x1, y1, adx, ady, pos, s, fx, fy)) expected_segs.push_back(s);
		if (border_entry(x2, y2, adx, ady, pos, s, tx, ty)) expected_segs.push_back(s);
		expected_segs.push_back(clipped_seg(fx, fy, tx, ty, 1));
	endfunction

	// send one line, bursts with random gaps
	task automatic send_line(int x1, int y1, int x2, int y2);
		if (burst_left == 0) begin
			repeat ($urandom_range(1, 6)) @(negedge clk);
			burst_left = $urandom_range(1, 12);
		end
		burst_left--;
		push <= 1'b1;
		start_x <= lswc_pkg::COORD_BITS'(x1);
		start_y <= lswc_pkg::COORD_BITS'(y1);
		end_x <= lswc_pkg::COORD_BITS'(x2);
		end_y <= lswc_pkg::COORD_BITS'(y2);
		do @(posedge clk); while (full);
		predict_clip(longint'($signed(lswc_pkg::COORD_BITS'(x1))),
			longint'($signed(lswc_pkg::COORD_BITS'(y1))),
			longint'($signed(lswc_pkg::COORD_BITS'(x2))),
			longint'($signed(lswc_pkg::COORD_BITS'(y2))));
		@(negedge clk);
		if (burst_left == 0) push <= 1'b0;
	endtask

	task automatic drain;
		if (burst_left != 0) push <= 1'b0;
		burst_left = 0;
		while (expected_segs.size() != 0) @(negedge clk);
		repeat (IDLE_WAIT) @(negedge clk);
	endtask

	task automatic write_reg(logic [lswc_pkg::CFG_IW-1:0] idx, logic [lswc_pkg::WW-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			lswc_pkg::CFG_WIN_LEFT: win_l = val;
			lswc_pkg::CFG_WIN_RIGHT: win_r = val;
			lswc_pkg::CFG_WIN_TOP: win_t = val;
			default: win_b = val;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_window(int l, int r, int t, int b);
		drain();
		write_reg(lswc_pkg::CFG_WIN_LEFT, lswc_pkg::WW'(l));
		write_reg(lswc_pkg::CFG_WIN_RIGHT, lswc_pkg::WW'(r));
		write_reg(lswc_pkg::CFG_WIN_TOP, lswc_pkg::WW'(t));
		write_reg(lswc_pkg::CFG_WIN_BOTTOM, lswc_pkg::WW'(b));
	endtask

	function automatic int pick_coord(int lo, int hi);
		case ($urandom_range(0, 9))
			0: return $urandom_range(0, 65535) - 32768;
			1: return $urandom_range(0, 1) ? 32767 : -32768;
			2, 3: return $urandom_range(lo, hi);
			default: return $urandom_range(0, 1) ? hi + $urandom_range(1, 400) :
				lo - $urandom_range(1, 400);
		endcase
	endfunction

	// directed extremes, every region and each single-result case
	task automatic test_directed;
		send_line(100, 100, 900, 900);
		send_line(-50, 500, 2000, 500);
		send_line(500, -50, 500, 2000);
		send_line(-10, -20, -30, 500);
		send_line(1100, 50, 1200, 700);
		send_line(50, -5, 700, -9);
		send_line(50, 1500, 700, 1100);
		send_line(-100, 300, 600, 700);
		send_line(1500, 300, 600, 700);
		send_line(300, -100, 600, 700);
		send_line(300, 1500, 600, 700);
		send_line(-100, -200, 500, 500);
		send_line(-300, 1300, 500, 500);
		send_line(1300, -30, 500, 500);
		send_line(1100, 1400, 500, 500);
		send_line(-100, -200, 1300, 1500);
		send_line(-32768, -32768, 32767, 32767);
		send_line(32767, -32768, -32768, 32767);
		send_line(-32768, 32767, 32767, -32767);
		send_line(-1, 1024, 1024, -1);
		send_line(0, 0, 1023, 1023);
		send_line(-1, 3, 1, 1023);
	endtask

	task automatic test_random(int n);
		for (int i = 0; i < n; i++)
			send_line(pick_coord(int'(win_l), int'(win_r)), pick_coord(int'(win_t), int'(win_b)),
				pick_coord(int'(win_l), int'(win_r)), pick_coord(int'(win_t), int'(win_b)));
	endtask

	// inverted and degenerate windows
	task automatic test_odd_windows;
		set_window(600, 200, 700, 100);
		test_random(25);
		set_window(4095, 4095, 0, 0);
		send_line(-32768, -32768, 32767, 32767);
		test_random(20);
	endtask

	initial begin
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_random(60);
		set_window(0, 4095, 0, 4095);
		test_random(60);
		set_window(1000, 1063, 2000, 2100);
		test_random(60);
		set_window(7, 7, 4090, 4095);
		test_random(30);
		test_odd_windows();
		set_window($urandom_range(0, 2000), $urandom_range(2001, 4095),
			$urandom_range(0, 2000), $urandom_range(2001, 4095));
		test_random(70);
		drain();
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule
`default_nettype wire

// File: files.f
rtl/lswc_pkg.sv
rtl/lswc_front.sv
rtl/lswc_jobq.sv
rtl/lswc_div.sv
rtl/lswc_back.sv
rtl/lswc_outq.sv
rtl/line_segment_window_clipper.sv
rtl/lswc_checker.sv
test/line_segment_window_clipper_tb.sv
